// ===== rtl/slts_pkg.sv =====
`default_nettype none
package slts_pkg;

   localparam int KW_MAX_LEN  = 9;
   localparam int KW_COUNT    = 28;
   localparam int KW_IDX_BITS = $clog2(KW_MAX_LEN);
   localparam int CNT_BITS    = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int MAX_PUSH    = 3;

   localparam logic [5:0] KIND_BAD     = 6'd0;
   localparam logic [5:0] KIND_EOF     = 6'd1;
   localparam logic [5:0] KIND_INT     = 6'd2;
   localparam logic [5:0] KIND_FLOAT   = 6'd3;
   localparam logic [5:0] KIND_IDENT   = 6'd4;
   localparam logic [5:0] KIND_STRING  = 6'd5;
   localparam logic [5:0] KIND_CHAR    = 6'd6;
   localparam logic [5:0] KIND_KW0     = 6'd7;
   localparam logic [5:0] KIND_NOT     = 6'd23;
   localparam logic [5:0] KIND_AND     = 6'd24;
   localparam logic [5:0] KIND_OR      = 6'd25;
   localparam logic [5:0] KIND_ARROW   = 6'd35;
   localparam logic [5:0] KIND_EQEQ    = 6'd36;
   localparam logic [5:0] KIND_ASSIGN  = 6'd37;
   localparam logic [5:0] KIND_NE      = 6'd38;
   localparam logic [5:0] KIND_COLON   = 6'd39;
   localparam logic [5:0] KIND_STAR    = 6'd40;
   localparam logic [5:0] KIND_LPAREN  = 6'd41;
   localparam logic [5:0] KIND_RPAREN  = 6'd42;
   localparam logic [5:0] KIND_LBRACE  = 6'd43;
   localparam logic [5:0] KIND_RBRACE  = 6'd44;
   localparam logic [5:0] KIND_COMMA   = 6'd45;
   localparam logic [5:0] KIND_SEMI    = 6'd46;
   localparam logic [5:0] KIND_AT      = 6'd47;
   localparam logic [5:0] KIND_PIPE    = 6'd48;
   localparam logic [5:0] KIND_AMP     = 6'd49;
   localparam logic [5:0] KIND_CARET   = 6'd50;
   localparam logic [5:0] KIND_TILDE   = 6'd51;
   localparam logic [5:0] KIND_PLUS    = 6'd52;
   localparam logic [5:0] KIND_MINUS   = 6'd53;
   localparam logic [5:0] KIND_SLASH   = 6'd54;
   localparam logic [5:0] KIND_PERCENT = 6'd55;
   localparam logic [5:0] KIND_DOT     = 6'd56;
   localparam logic [5:0] KIND_GE      = 6'd57;
   localparam logic [5:0] KIND_SHR     = 6'd58;
   localparam logic [5:0] KIND_GT      = 6'd59;
   localparam logic [5:0] KIND_LE      = 6'd60;
   localparam logic [5:0] KIND_SHL     = 6'd61;
   localparam logic [5:0] KIND_LT      = 6'd62;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_UNDER = "_";
   localparam logic [7:0] CH_DOT   = ".";
   localparam logic [7:0] CH_DQUOTE = "\"";
   localparam logic [7:0] CH_SQUOTE = "'";

   localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
      "let", "fn", "return", "struct", "interface", "true", "false", "while",
      "next", "stop", "if", "then", "else", "pub", "for", "in", "not", "and",
      "or", "xor", "mod", "sizeof", "as", "match", "enum", "const", "defer",
      "embed"};
   localparam int KW_LEN [KW_COUNT] = '{
      3, 2, 6, 6, 9, 4, 5, 5, 4, 4, 2, 4, 4, 3, 3, 2, 3, 3, 2, 3, 3, 6, 2, 5,
      4, 5, 5, 5};

   typedef struct packed {
      logic [5:0]          kind;
      logic [CNT_BITS-1:0] line;
      logic [CNT_BITS-1:0] column;
      logic [CNT_BITS-1:0] start;
      logic [CNT_BITS-1:0] length;
      logic                lead;
      logic                last;
   } token_type;

   typedef struct packed {
      logic [1:0]               count;
      token_type [MAX_PUSH-1:0] tok;
   } push_type;

   function automatic token_type mk_tok(input logic [5:0] kind,
                                        input logic [CNT_BITS-1:0] line,
                                        input logic [CNT_BITS-1:0] column,
                                        input logic [CNT_BITS-1:0] start,
                                        input logic [CNT_BITS-1:0] length,
                                        input logic lead);
      token_type t;
      t.kind   = kind;
      t.line   = line;
      t.column = column;
      t.start  = start;
      t.length = length;
      t.lead   = lead;
      t.last   = 1'b0;
      return t;
   endfunction

   function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_UNDER;
   endfunction

   function automatic logic is_pairable(input logic [7:0] c);
      return c == "=" || c == "!" || c == "|" || c == "&" || c == ">" || c == "<" ||
             c == "/";
   endfunction

   function automatic logic is_simple(input logic [7:0] c);
      return c == ":" || c == "*" || c == "(" || c == ")" || c == "{" || c == "}" ||
             c == "," || c == ";" || c == "@" || c == "^" || c == "~" || c == "+" ||
             c == "-" || c == "%" || c == CH_DOT;
   endfunction

   function automatic logic [5:0] simple_kind(input logic [7:0] c);
      logic [5:0] k;
      unique case (c)
         ":":     k = KIND_COLON;
         "*":     k = KIND_STAR;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         ",":     k = KIND_COMMA;
         ";":     k = KIND_SEMI;
         "@":     k = KIND_AT;
         "^":     k = KIND_CARET;
         "~":     k = KIND_TILDE;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "%":     k = KIND_PERCENT;
         default: k = KIND_DOT;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] p);
      logic [5:0] k;
      unique case (p)
         "=":     k = KIND_ASSIGN;
         "!":     k = KIND_NOT;
         "|":     k = KIND_PIPE;
         "&":     k = KIND_AMP;
         ">":     k = KIND_GT;
         "<":     k = KIND_LT;
         default: k = KIND_SLASH;
      endcase
      return k;
   endfunction

   function automatic logic pair_hit(input logic [7:0] p, input logic [7:0] c);
      return (p == "=" && (c == ">" || c == "=")) || (p == "!" && c == "=") ||
             (p == "|" && c == "|") || (p == "&" && c == "&") ||
             (p == ">" && (c == "=" || c == ">")) || (p == "<" && (c == "=" || c == "<"));
   endfunction

   function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
      logic [5:0] k;
      priority if (p == "=" && c == ">") k = KIND_ARROW;
      else if (p == "=") k = KIND_EQEQ;
      else if (p == "!") k = KIND_NE;
      else if (p == "|") k = KIND_OR;
      else if (p == "&") k = KIND_AND;
      else if (p == ">" && c == "=") k = KIND_GE;
      else if (p == ">") k = KIND_SHR;
      else if (c == "=") k = KIND_LE;
      else k = KIND_SHL;
      return k;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/slts_chan_if.sv =====
`default_nettype none
interface slts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_source;
   modport source (output valid, char_code, end_of_source, input ready);
   modport sink (input valid, char_code, end_of_source, output ready);
endinterface

interface slts_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [15:0] line_number;
   logic [15:0] column_number;
   logic [15:0] start_offset;
   logic [15:0] token_length;
   logic        leading_space;
   logic        last_of_run;
   modport source (output valid, token_kind, line_number, column_number, start_offset,
                   token_length, leading_space, last_of_run, input ready);
   modport sink (input valid, token_kind, line_number, column_number, start_offset,
                 token_length, leading_space, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/slts_front.sv =====
`default_nettype none
module slts_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic [7:0]       char_code,
   input  wire logic             end_of_source,
   output slts_pkg::push_type    push
);
   typedef enum logic [3:0] {
      MODE_BETWEEN, MODE_AFTER, MODE_NUMBER, MODE_IDENT,
      MODE_STRING, MODE_CHAR, MODE_COMMENT, MODE_PAIR
   } mode_type;

   localparam int CB = slts_pkg::CNT_BITS;

   mode_type         mode_ff, mode_in;
   logic [7:0]       prefix_ff [slts_pkg::KW_MAX_LEN];
   logic [7:0]       prefix_in [slts_pkg::KW_MAX_LEN];
   logic [CB-1:0]    len_ff, len_in;
   logic             seen_ff, seen_in;
   logic [7:0]       pend_ff, pend_in;
   logic [CB-1:0]    bp_ff, bp_in;
   logic [CB-1:0]    line_ff, line_in;
   logic [CB-1:0]    col_ff, col_in;
   logic [CB-1:0]    start_ff, start_in;
   logic             space_ff, space_in;
   logic             halted_ff, halted_in;

   logic [CB-1:0]    col_inc, bp_inc, len_inc;
   logic [5:0]       kw_kind, num_kind;
   logic             do_start, start_space, kw_eq;
   logic [1:0]       n;
   logic [7:0]       c;

   assign c        = char_code;
   assign col_inc  = slts_pkg::sat_inc(col_ff);
   assign bp_inc   = slts_pkg::sat_inc(bp_ff);
   assign len_inc  = slts_pkg::sat_inc(len_ff);
   assign num_kind = seen_ff ? slts_pkg::KIND_FLOAT : slts_pkg::KIND_INT;

   // keyword lookup, all entries compared at once
   always_comb begin
      kw_kind = slts_pkg::KIND_IDENT;
      for (int i = slts_pkg::KW_COUNT - 1; i >= 0; i--) begin
         kw_eq = (len_ff == CB'(slts_pkg::KW_LEN[i]));
         for (int j = 0; j < slts_pkg::KW_MAX_LEN; j++) begin
            if (j < slts_pkg::KW_LEN[i]) begin
               if (prefix_ff[j] !=
                   slts_pkg::KW_TEXT[i][8*(slts_pkg::KW_LEN[i]-1-j) +: 8]) begin
                  kw_eq = 1'b0;
               end
            end
         end
         if (kw_eq) begin
            kw_kind = slts_pkg::KIND_KW0 + 6'(i);
         end
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      prefix_in   = prefix_ff;
      len_in      = len_ff;
      seen_in     = seen_ff;
      pend_in     = pend_ff;
      bp_in       = bp_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      start_in    = start_ff;
      space_in    = space_ff;
      halted_in   = halted_ff;
      push        = '0;
      n           = 2'd0;
      do_start    = 1'b0;
      start_space = space_ff;
      if (fire && !halted_ff) begin
         if (end_of_source) begin
            unique case (mode_ff)
               MODE_NUMBER: begin
                  push.tok[n] = slts_pkg::mk_tok(num_kind, line_ff, col_ff, start_ff,
                                                 len_ff, space_ff);
                  n = n + 2'd1;
               end
               MODE_IDENT: begin
                  push.tok[n] = slts_pkg::mk_tok(kw_kind, line_ff, col_ff, start_ff,
                                                 len_ff, space_ff);
                  n = n + 2'd1;
               end
               MODE_STRING: begin
                  push.tok[n] = slts_pkg::mk_tok(slts_pkg::KIND_BAD, line_ff, col_ff,
                                                 start_ff, '0, space_ff);
                  n = n + 2'd1;
               end
               MODE_CHAR: begin
                  col_in = col_inc;
                  bp_in  = bp_inc;
                  push.tok[n] = slts_pkg::mk_tok(slts_pkg::KIND_CHAR, line_ff, col_inc,
                                                 start_ff, len_ff, space_ff);
                  n = n + 2'd1;
               end
               MODE_PAIR: begin
                  push.tok[n] = slts_pkg::mk_tok(slts_pkg::single_kind(pend_ff), line_ff,
                                                 col_ff, start_ff, CB'(1), space_ff);
                  n = n + 2'd1;
               end
               default: ;
            endcase
            push.tok[n] = slts_pkg::mk_tok(slts_pkg::KIND_EOF, line_ff, col_in, bp_in,
                                           '0, space_ff);
            n = n + 2'd1;
            halted_in = 1'b1;
         end else begin
            unique case (mode_ff)
               MODE_AFTER: begin
                  start_space = 1'b0;
                  do_start    = 1'b1;
               end
               MODE_NUMBER: begin
                  if (slts_pkg::is_digit(c)) begin
                     bp_in  = bp_inc;
                     col_in = col_inc;
                     len_in = len_inc;
                  end else if (c == slts_pkg::CH_DOT) begin
                     if (seen_ff) begin
                        push.tok[0] = slts_pkg::mk_tok(slts_pkg::KIND_BAD, line_ff, col_ff,
                                                       start_ff, '0, space_ff);
                        push.tok[1] = slts_pkg::mk_tok(slts_pkg::KIND_EOF, line_ff, col_ff,
                                                       bp_ff, '0, space_ff);
                        n         = 2'd2;
                        halted_in = 1'b1;
                     end else begin
                        seen_in = 1'b1;
                        bp_in   = bp_inc;
                        col_in  = col_inc;
                        len_in  = len_inc;
                     end
                  end else begin
                     push.tok[n] = slts_pkg::mk_tok(num_kind, line_ff, col_ff, start_ff,
                                                    len_ff, space_ff);
                     n           = n + 2'd1;
                     start_space = 1'b0;
                     do_start    = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (slts_pkg::is_word(c)) begin
                     if (len_ff < CB'(slts_pkg::KW_MAX_LEN)) begin
                        prefix_in[len_ff[slts_pkg::KW_IDX_BITS-1:0]] = c;
                     end
                     len_in = len_inc;
                     bp_in  = bp_inc;
                     col_in = col_inc;
                  end else begin
                     push.tok[n] = slts_pkg::mk_tok(kw_kind, line_ff, col_ff, start_ff,
                                                    len_ff, space_ff);
                     n           = n + 2'd1;
                     start_space = 1'b0;
                     do_start    = 1'b1;
                  end
               end
               MODE_STRING: begin
                  bp_in  = bp_inc;
                  col_in = col_inc;
                  len_in = len_inc;
                  if (c == slts_pkg::CH_DQUOTE) begin
                     push.tok[n] = slts_pkg::mk_tok(slts_pkg::KIND_STRING, line_ff, col_inc,
                                                    start_ff, len_inc, space_ff);
                     n       = n + 2'd1;
                     mode_in = MODE_AFTER;
                  end
               end
               MODE_CHAR: begin
                  bp_in  = bp_inc;
                  col_in = col_inc;
                  if (c == slts_pkg::CH_SQUOTE) begin
                     push.tok[n] = slts_pkg::mk_tok(slts_pkg::KIND_CHAR, line_ff, col_inc,
                                                    start_ff, len_ff, space_ff);
                     n       = n + 2'd1;
                     mode_in = MODE_AFTER;
                  end else begin
                     len_in = len_inc;
                  end
               end
               MODE_COMMENT: begin
                  if (c == slts_pkg::CH_LF) begin
                     do_start = 1'b1;
                  end else begin
                     bp_in  = bp_inc;
                     col_in = col_inc;
                  end
               end
               MODE_PAIR: begin
                  if (pend_ff == "/" && c == "/") begin
                     bp_in   = bp_inc;
                     col_in  = col_inc;
                     mode_in = MODE_COMMENT;
                  end else if (slts_pkg::pair_hit(pend_ff, c)) begin
                     bp_in  = bp_inc;
                     col_in = col_inc;
                     push.tok[n] = slts_pkg::mk_tok(slts_pkg::pair_kind(pend_ff, c), line_ff,
                                                    col_inc, start_ff, CB'(2), space_ff);
                     n       = n + 2'd1;
                     mode_in = MODE_AFTER;
                  end else begin
                     push.tok[n] = slts_pkg::mk_tok(slts_pkg::single_kind(pend_ff), line_ff,
                                                    col_ff, start_ff, CB'(1), space_ff);
                     n           = n + 2'd1;
                     start_space = 1'b0;
                     do_start    = 1'b1;
                  end
               end
               default: do_start = 1'b1;
            endcase
            if (do_start) begin
               mode_in  = MODE_BETWEEN;
               space_in = start_space;
               bp_in    = bp_inc;
               col_in   = col_inc;
               if (slts_pkg::is_space(c)) begin
                  space_in = 1'b1;
                  if (c == slts_pkg::CH_LF) begin
                     line_in = slts_pkg::sat_inc(line_ff);
                     col_in  = CB'(1);
                  end
               end else begin
                  start_in = bp_ff;
                  len_in   = '0;
                  if (slts_pkg::is_digit(c)) begin
                     mode_in = MODE_NUMBER;
                     seen_in = 1'b0;
                     len_in  = CB'(1);
                  end else if (slts_pkg::is_alpha(c) || c == slts_pkg::CH_UNDER) begin
                     prefix_in[0] = c;
                     len_in       = CB'(1);
                     mode_in      = MODE_IDENT;
                  end else if (c == slts_pkg::CH_DQUOTE) begin
                     len_in  = CB'(1);
                     mode_in = MODE_STRING;
                  end else if (c == slts_pkg::CH_SQUOTE) begin
                     mode_in = MODE_CHAR;
                  end else if (slts_pkg::is_pairable(c)) begin
                     pend_in = c;
                     mode_in = MODE_PAIR;
                  end else if (slts_pkg::is_simple(c)) begin
                     push.tok[n] = slts_pkg::mk_tok(slts_pkg::simple_kind(c), line_ff,
                                                    col_inc, bp_ff, CB'(1), start_space);
                     n       = n + 2'd1;
                     mode_in = MODE_AFTER;
                  end else begin
                     push.tok[n] = slts_pkg::mk_tok(slts_pkg::KIND_BAD, line_ff, col_inc,
                                                    bp_ff, '0, start_space);
                     n = n + 2'd1;
                     push.tok[n] = slts_pkg::mk_tok(slts_pkg::KIND_EOF, line_ff, col_inc,
                                                    bp_inc, '0, start_space);
                     n         = n + 2'd1;
                     halted_in = 1'b1;
                  end
               end
            end
         end
      end
      if (n != 2'd0) begin
         push.tok[n - 2'd1].last = 1'b1;
      end
      push.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_BETWEEN;
         len_ff    <= '0;
         seen_ff   <= 1'b0;
         pend_ff   <= '0;
         bp_ff     <= '0;
         line_ff   <= CB'(1);
         col_ff    <= '0;
         start_ff  <= '0;
         space_ff  <= 1'b1;
         halted_ff <= 1'b0;
         for (int i = 0; i < slts_pkg::KW_MAX_LEN; i++) begin
            prefix_ff[i] <= '0;
         end
      end else begin
         mode_ff   <= mode_in;
         len_ff    <= len_in;
         seen_ff   <= seen_in;
         pend_ff   <= pend_in;
         bp_ff     <= bp_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         start_ff  <= start_in;
         space_ff  <= space_in;
         halted_ff <= halted_in;
         prefix_ff <= prefix_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/slts_queue.sv =====
`default_nettype none
module slts_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire slts_pkg::push_type  push,
   input  wire logic                pop,
   output slts_pkg::token_type      head,
   output logic                     not_empty,
   output logic                     room
);
   localparam int PB = slts_pkg::QPTR_BITS;

   slts_pkg::token_type mem [slts_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PB:0]   count_ff, count_in;

   assign head      = mem[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign room      = count_ff <= (PB+1)'(slts_pkg::QUEUE_DEPTH - slts_pkg::MAX_PUSH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PB'(push.count);
      rd_ptr_in = rd_ptr_ff + PB'(pop);
      count_in  = count_ff + (PB+1)'(push.count) - (PB+1)'(pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < slts_pkg::MAX_PUSH; k++) begin
         if (k < int'(push.count)) begin
            mem[wr_ptr_ff + PB'(k)] <= push.tok[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/source_lexer_token_scanner_unit.sv =====
// channel  dir  transaction
// req      in   char_code[7:0], end_of_source
// rsp      out  token_kind, line/column/offset/length, leading_space, last_of_run
//
// One req transaction per cycle; its tokens (0 to 3) land in an 8-entry queue the
// next cycle and leave one per cycle with rsp.ready high; rsp bounds throughput.
// req.ready is low while the queue has fewer than 3 free entries.
// Synchronous reset empties the queue and returns the scanner to line 1, column 0.
// After an EOF token all req transactions are taken and dropped until reset.
`default_nettype none
module source_lexer_token_scanner_unit (
   input wire logic    clock,
   input wire logic    reset,
   slts_req_if.sink    req,
   slts_rsp_if.source  rsp
);
   slts_pkg::push_type  push;
   slts_pkg::token_type head;
   logic                fire, room, not_empty;

   assign req.ready = room;
   assign fire      = req.valid && room;

   slts_front u_front (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .char_code     (req.char_code),
      .end_of_source (req.end_of_source),
      .push          (push)
   );

   slts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (not_empty && rsp.ready),
      .head      (head),
      .not_empty (not_empty),
      .room      (room)
   );

   assign rsp.valid         = not_empty;
   assign rsp.token_kind    = head.kind;
   assign rsp.line_number   = head.line;
   assign rsp.column_number = head.column;
   assign rsp.start_offset  = head.start;
   assign rsp.token_length  = head.length;
   assign rsp.leading_space = head.lead;
   assign rsp.last_of_run   = head.last;
endmodule
`default_nettype wire

// ===== rtl/slts_checker.sv =====
`default_nettype none
module slts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [5:0]  rsp_kind,
   input wire logic [15:0] rsp_line,
   input wire logic [15:0] rsp_length,
   input wire logic        rsp_last
);
   a_eof_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == slts_pkg::KIND_EOF |=> !rsp_valid)
      else $error("token after EOF");

   a_bad_then_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == slts_pkg::KIND_BAD |-> !rsp_last)
      else $error("BAD token closes a run");

   a_eof_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == slts_pkg::KIND_EOF |-> rsp_last && rsp_length == '0)
      else $error("malformed EOF token");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line != '0)
      else $error("line number zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped");
endmodule

bind source_lexer_token_scanner_unit slts_checker u_slts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_kind   (rsp.token_kind),
   .rsp_line   (rsp.line_number),
   .rsp_length (rsp.token_length),
   .rsp_last   (rsp.last_of_run)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
   localparam logic [5:0] NO_KIND = 6'h3F;
   localparam int         CB      = slts_pkg::CNT_BITS;

   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_AFTER, SCAN_NUM, SCAN_WORD, SCAN_STR, SCAN_CHR, SCAN_CMT, SCAN_OP
   } scan_mode_type;

   typedef struct {
      logic [7:0] c;
      logic       eos;
      logic       typed;
      logic [5:0] kind;
   } stim_row_type;

   logic clock;
   logic reset;

   slts_req_if req_ch ();
   slts_rsp_if rsp_ch ();

   source_lexer_token_scanner_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // scanner state mirror
   scan_mode_type       mode;
   logic [7:0]          word_head [slts_pkg::KW_MAX_LEN];
   logic [CB-1:0]       lex_len;
   logic                had_dot;
   logic [7:0]          held_op;
   logic [CB-1:0]       byte_pos;
   logic [CB-1:0]       line_no;
   logic [CB-1:0]       col_no;
   logic [CB-1:0]       tok_start;
   logic                lead_ws;
   logic                stopped;

   slts_pkg::token_type tokens_due [$];
   slts_pkg::token_type step_tokens [$];

   string keywords [slts_pkg::KW_COUNT] = '{
      "let", "fn", "return", "struct", "interface", "true", "false", "while",
      "next", "stop", "if", "then", "else", "pub", "for", "in", "not", "and",
      "or", "xor", "mod", "sizeof", "as", "match", "enum", "const", "defer", "embed"};

   string op_texts [32] = '{
      ":", "*", "(", ")", "{", "}", ",", ";", "@", "^", "~", "+", "-", "%", ".",
      "=>", "==", "=", "!=", "!", "||", "|", "&&", "&", ">=", ">>", ">", "<=", "<<",
      "<", "/", "/"};

   int  errors;
   int  hold_cycles;
   bit  calm;
   bit  last_num;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("tb NOT OK");
      $finish;
   end

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic logic [CB-1:0] bump(input logic [CB-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic bit ch_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit ch_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit ch_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit ch_word(input logic [7:0] c);
      return ch_alpha(c) || ch_digit(c) || c == "_";
   endfunction

   function automatic bit ch_pairable(input logic [7:0] c);
      return c == "=" || c == "!" || c == "|" || c == "&" || c == ">" || c == "<" ||
             c == "/";
   endfunction

   function automatic logic [5:0] lone_op(input logic [7:0] c);
      case (c)
         ":": return slts_pkg::KIND_COLON;
         "*": return slts_pkg::KIND_STAR;
         "(": return slts_pkg::KIND_LPAREN;
         ")": return slts_pkg::KIND_RPAREN;
         "{": return slts_pkg::KIND_LBRACE;
         "}": return slts_pkg::KIND_RBRACE;
         ",": return slts_pkg::KIND_COMMA;
         ";": return slts_pkg::KIND_SEMI;
         "@": return slts_pkg::KIND_AT;
         "^": return slts_pkg::KIND_CARET;
         "~": return slts_pkg::KIND_TILDE;
         "+": return slts_pkg::KIND_PLUS;
         "-": return slts_pkg::KIND_MINUS;
         "%": return slts_pkg::KIND_PERCENT;
         ".": return slts_pkg::KIND_DOT;
         default: return NO_KIND;
      endcase
   endfunction

   function automatic logic [5:0] held_alone(input logic [7:0] p);
      case (p)
         "=": return slts_pkg::KIND_ASSIGN;
         "!": return slts_pkg::KIND_NOT;
         "|": return slts_pkg::KIND_PIPE;
         "&": return slts_pkg::KIND_AMP;
         ">": return slts_pkg::KIND_GT;
         "<": return slts_pkg::KIND_LT;
         default: return slts_pkg::KIND_SLASH;
      endcase
   endfunction

   function automatic logic [5:0] joined_op(input logic [7:0] p, input logic [7:0] c);
      if (p == "=" && c == ">") return slts_pkg::KIND_ARROW;
      if (p == "=" && c == "=") return slts_pkg::KIND_EQEQ;
      if (p == "!" && c == "=") return slts_pkg::KIND_NE;
      if (p == "|" && c == "|") return slts_pkg::KIND_OR;
      if (p == "&" && c == "&") return slts_pkg::KIND_AND;
      if (p == ">" && c == "=") return slts_pkg::KIND_GE;
      if (p == ">" && c == ">") return slts_pkg::KIND_SHR;
      if (p == "<" && c == "=") return slts_pkg::KIND_LE;
      if (p == "<" && c == "<") return slts_pkg::KIND_SHL;
      return NO_KIND;
   endfunction

   function automatic logic [5:0] word_class();
      bit hit;
      for (int i = 0; i < slts_pkg::KW_COUNT; i++) begin
         if (lex_len == keywords[i].len() && lex_len <= slts_pkg::KW_MAX_LEN) begin
            hit = 1'b1;
            for (int j = 0; j < keywords[i].len(); j++)
               if (word_head[j] != keywords[i][j]) hit = 1'b0;
            if (hit) return slts_pkg::KIND_KW0 + 6'(i);
         end
      end
      return slts_pkg::KIND_IDENT;
   endfunction

   task automatic add_token(input logic [5:0] kind, input logic [CB-1:0] start,
                            input logic [CB-1:0] len);
      if (step_tokens.size() < 3)
         step_tokens.push_back(slts_pkg::mk_tok(kind, line_no, col_no, start, len,
                                                lead_ws));
   endtask

   task automatic consume();
      byte_pos = bump(byte_pos);
      col_no   = bump(col_no);
   endtask

   task automatic close_source();
      add_token(slts_pkg::KIND_EOF, byte_pos, '0);
      stopped = 1'b1;
   endtask

   task automatic reject();
      add_token(slts_pkg::KIND_BAD, tok_start, '0);
      close_source();
   endtask

   task automatic open_token(input logic [7:0] c);
      logic [5:0] k;
      if (ch_space(c)) begin
         lead_ws = 1'b1;
         if (c == slts_pkg::CH_LF) begin
            line_no = bump(line_no);
            col_no  = '0;
         end
         consume();
         return;
      end
      tok_start = byte_pos;
      lex_len   = '0;
      if (ch_digit(c)) begin
         mode = SCAN_NUM;
         had_dot = 1'b0;
         lex_len = CB'(1);
      end else if (ch_alpha(c) || c == slts_pkg::CH_UNDER) begin
         word_head[0] = c;
         lex_len = CB'(1);
         mode = SCAN_WORD;
      end else if (c == slts_pkg::CH_DQUOTE) begin
         lex_len = CB'(1);
         mode = SCAN_STR;
      end else if (c == slts_pkg::CH_SQUOTE) begin
         mode = SCAN_CHR;
      end else if (ch_pairable(c)) begin
         held_op = c;
         mode = SCAN_OP;
      end else begin
         k = lone_op(c);
         consume();
         if (k != NO_KIND) begin
            add_token(k, tok_start, CB'(1));
            mode = SCAN_AFTER;
         end else begin
            reject();
         end
         return;
      end
      consume();
   endtask

   // returns 1 when the byte has to be scanned again in the new mode
   task automatic scan_byte(input logic [7:0] c, output bit again);
      logic [5:0] k;
      again = 1'b0;
      case (mode)
         SCAN_AFTER: begin
            lead_ws = 1'b0;
            mode = SCAN_IDLE;
            open_token(c);
         end
         SCAN_NUM: begin
            if (ch_digit(c)) begin
               consume();
               lex_len = bump(lex_len);
            end else if (c == slts_pkg::CH_DOT) begin
               if (had_dot) begin
                  reject();
               end else begin
                  had_dot = 1'b1;
                  consume();
                  lex_len = bump(lex_len);
               end
            end else begin
               add_token(had_dot ? slts_pkg::KIND_FLOAT : slts_pkg::KIND_INT, tok_start,
                         lex_len);
               mode = SCAN_AFTER;
               again = 1'b1;
            end
         end
         SCAN_WORD: begin
            if (ch_word(c)) begin
               if (lex_len < slts_pkg::KW_MAX_LEN)
                  word_head[lex_len[slts_pkg::KW_IDX_BITS-1:0]] = c;
               lex_len = bump(lex_len);
               consume();
            end else begin
               add_token(word_class(), tok_start, lex_len);
               mode = SCAN_AFTER;
               again = 1'b1;
            end
         end
         SCAN_STR: begin
            consume();
            lex_len = bump(lex_len);
            if (c == slts_pkg::CH_DQUOTE) begin
               add_token(slts_pkg::KIND_STRING, tok_start, lex_len);
               mode = SCAN_AFTER;
            end
         end
         SCAN_CHR: begin
            consume();
            if (c == slts_pkg::CH_SQUOTE) begin
               add_token(slts_pkg::KIND_CHAR, tok_start, lex_len);
               mode = SCAN_AFTER;
            end else begin
               lex_len = bump(lex_len);
            end
         end
         SCAN_CMT: begin
            if (c == slts_pkg::CH_LF) begin
               mode = SCAN_IDLE;
               again = 1'b1;
            end else begin
               consume();
            end
         end
         SCAN_OP: begin
            k = joined_op(held_op, c);
            if (held_op == "/" && c == "/") begin
               consume();
               mode = SCAN_CMT;
            end else if (k != NO_KIND) begin
               consume();
               add_token(k, tok_start, CB'(2));
               mode = SCAN_AFTER;
            end else begin
               add_token(held_alone(held_op), tok_start, CB'(1));
               mode = SCAN_AFTER;
               again = 1'b1;
            end
         end
         default: begin
            mode = SCAN_IDLE;
            open_token(c);
         end
      endcase
   endtask

   task automatic scan_end();
      case (mode)
         SCAN_NUM:  add_token(had_dot ? slts_pkg::KIND_FLOAT : slts_pkg::KIND_INT,
                              tok_start, lex_len);
         SCAN_WORD: add_token(word_class(), tok_start, lex_len);
         SCAN_STR: begin
            reject();
            return;
         end
         SCAN_CHR: begin
            consume();
            add_token(slts_pkg::KIND_CHAR, tok_start, lex_len);
         end
         SCAN_OP:   add_token(held_alone(held_op), tok_start, CB'(1));
         default: ;
      endcase
      close_source();
   endtask

   task automatic predict_tokens(input logic [7:0] c, input logic eos);
      bit again;
      step_tokens.delete();
      if (stopped) return;
      if (eos) begin
         scan_end();
      end else begin
         for (int g = 0; g < 4 && !stopped; g++) begin
            scan_byte(c, again);
            if (!again) break;
         end
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
   endtask

   task automatic send(input logic [7:0] c, input logic eos, input logic typed = 1'b0,
                       input logic [5:0] kind = '0);
      while (!calm && $urandom_range(99) < 16) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.char_code     <= c;
      req_ch.end_of_source <= eos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_tokens(c, eos);
      if (typed && step_tokens.size() > 0) step_tokens[0].kind = kind;
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
   endtask

   function automatic logic [7:0] any_byte_but(input logic [7:0] x);
      logic [7:0] b;
      b = 8'($urandom_range(255));
      return (b == x) ? b ^ 8'h80 : b;
   endfunction

   task automatic send_random_token();
      int pick;
      int n;
      string s;
      pick = $urandom_range(9);
      case (pick)
         0, 1: begin
            if ($urandom_range(1)) begin
               send_text(keywords[$urandom_range(slts_pkg::KW_COUNT - 1)]);
            end else begin
               n = $urandom_range(12, 1);
               for (int i = 0; i < n; i++) begin
                  case ($urandom_range(3))
                     0: send(8'("a" + $urandom_range(25)), 1'b0);
                     1: send(8'("A" + $urandom_range(25)), 1'b0);
                     2: send(i == 0 ? slts_pkg::CH_UNDER : 8'("0" + $urandom_range(9)),
                             1'b0);
                     default: send(slts_pkg::CH_UNDER, 1'b0);
                  endcase
               end
            end
            last_num = 1'b0;
         end
         2, 3: begin
            if (last_num) send(" ", 1'b0);
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++) send(8'("0" + $urandom_range(9)), 1'b0);
            if ($urandom_range(1)) begin
               send(slts_pkg::CH_DOT, 1'b0);
               n = $urandom_range(3);
               for (int i = 0; i < n; i++) send(8'("0" + $urandom_range(9)), 1'b0);
            end
            last_num = 1'b1;
         end
         4: begin
            send(slts_pkg::CH_DQUOTE, 1'b0);
            n = $urandom_range(4);
            for (int i = 0; i < n; i++) send(any_byte_but(slts_pkg::CH_DQUOTE), 1'b0);
            send(slts_pkg::CH_DQUOTE, 1'b0);
            last_num = 1'b0;
         end
         5: begin
            send(slts_pkg::CH_SQUOTE, 1'b0);
            n = $urandom_range(2);
            for (int i = 0; i < n; i++) send(any_byte_but(slts_pkg::CH_SQUOTE), 1'b0);
            send(slts_pkg::CH_SQUOTE, 1'b0);
            last_num = 1'b0;
         end
         6: begin
            send_text("//");
            n = $urandom_range(4);
            for (int i = 0; i < n; i++) send(any_byte_but(slts_pkg::CH_LF), 1'b0);
            send(slts_pkg::CH_LF, 1'b0);
            last_num = 1'b0;
         end
         default: begin
            s = op_texts[$urandom_range(31)];
            if (last_num && s[0] == slts_pkg::CH_DOT) send(" ", 1'b0);
            send_text(s);
            last_num = 1'b0;
         end
      endcase
      case ($urandom_range(5))
         0: send(" ", 1'b0);
         1: send(slts_pkg::CH_LF, 1'b0);
         2: send(8'($urandom_range(13, 9)), 1'b0);
         default: ;
      endcase
      if (!ch_digit(req_ch.char_code) && req_ch.char_code != slts_pkg::CH_DOT)
         last_num = 1'b0;
   endtask

   task automatic send_ending();
      case ($urandom_range(6))
         0: ;
         1: send("$", 1'b0);
         2: send(8'($urandom_range(255, 128)), 1'b0);
         3: send_text(" 1.2.");
         4: send_text(" \"ab");
         5: send_text(" 'q");
         default: send_text(" <");
      endcase
      send(8'h00, 1'b1);
      send("a", 1'b0);
      send(8'h00, 1'b1);
   endtask

   // token checker and ready generator
   initial begin
      slts_pkg::token_type got, want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = slts_pkg::mk_tok(rsp_ch.token_kind, rsp_ch.line_number,
                                   rsp_ch.column_number, rsp_ch.start_offset,
                                   rsp_ch.token_length, rsp_ch.leading_space);
            got.last = rsp_ch.last_of_run;
            if (tokens_due.size() == 0) begin
               report($sformatf("token kind %0d with none due", got.kind));
            end else begin
               want = tokens_due.pop_front();
               if (got.kind != want.kind)
                  report($sformatf("kind %0d, want %0d", got.kind, want.kind));
               if (got.line != want.line)
                  report($sformatf("line %0d, want %0d", got.line, want.line));
               if (got.column != want.column)
                  report($sformatf("column %0d, want %0d", got.column, want.column));
               if (got.start != want.start)
                  report($sformatf("offset %0d, want %0d", got.start, want.start));
               if (got.length != want.length)
                  report($sformatf("length %0d, want %0d", got.length, want.length));
               if (got.lead != want.lead)
                  report($sformatf("leading_space %0d, want %0d", got.lead, want.lead));
               if (got.last != want.last)
                  report($sformatf("last_of_run %0d, want %0d", got.last, want.last));
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm || $urandom_range(99) >= 16;
         end
      end
   end

   initial begin
      stim_row_type rows [$];
      int sent;
      int waited;

      errors = 0;
      hold_cycles = 0;
      calm = 1'b0;
      last_num = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.char_code = '0;
      req_ch.end_of_source = 1'b0;
      rsp_ch.ready = 1'b0;

      mode = SCAN_IDLE;
      foreach (word_head[i]) word_head[i] = '0;
      lex_len = '0;
      had_dot = 1'b0;
      held_op = '0;
      byte_pos = '0;
      line_no = CB'(1);
      col_no = '0;
      tok_start = '0;
      lead_ws = 1'b1;
      stopped = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      rows = '{
         '{"\t", 0, 0, 0}, '{"=", 0, 0, 0}, '{">", 0, 1, slts_pkg::KIND_ARROW},
         '{"!", 0, 0, 0}, '{"=", 0, 1, slts_pkg::KIND_NE}, '{"&", 0, 0, 0},
         '{"&", 0, 1, slts_pkg::KIND_AND}, '{"|", 0, 0, 0},
         '{"|", 0, 1, slts_pkg::KIND_OR},
         '{"!", 0, 0, 0}, '{"_", 0, 1, slts_pkg::KIND_NOT}, '{"9", 0, 0, 0},
         '{" ", 0, 1, slts_pkg::KIND_IDENT}, '{"4", 0, 0, 0}, '{".", 0, 0, 0},
         '{"5", 0, 0, 0}, '{";", 0, 1, slts_pkg::KIND_FLOAT}, '{"\"", 0, 0, 0},
         '{8'hFF, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{"\"", 0, 1, slts_pkg::KIND_STRING},
         '{"'", 0, 0, 0}, '{"z", 0, 0, 0}, '{"'", 0, 1, slts_pkg::KIND_CHAR},
         '{"/", 0, 0, 0}, '{"/", 0, 0, 0}, '{8'h80, 0, 0, 0},
         '{slts_pkg::CH_LF, 0, 0, 0}, '{"<", 0, 0, 0}, '{"<", 0, 1, slts_pkg::KIND_SHL}};
      foreach (rows[i]) send(rows[i].c, rows[i].eos, rows[i].typed, rows[i].kind);
      send_text(" interface sizeof return embed ");

      sent = 0;
      while (sent < 18) begin
         send_random_token();
         sent++;
      end

      // receiver stalls while the sender keeps pushing
      hold_cycles = 150;
      calm = 1'b1;
      repeat (12) send_random_token();
      calm = 1'b0;

      req_ch.valid <= 1'b0;
      while (tokens_due.size() > 0) @(posedge clock);

      calm = 1'b1;
      repeat (10) send_random_token();
      calm = 1'b0;
      repeat (14) send_random_token();
      send_ending();
      req_ch.valid <= 1'b0;

      waited = 0;
      while (tokens_due.size() > 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (errors == 0 && tokens_due.size() == 0) begin
         $display("tb OK");
      end else begin
         if (tokens_due.size() > 0)
            report($sformatf("%0d tokens never came", tokens_due.size()));
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
